[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each macro checks on the rising edge of clock and is quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every checked edge.
`define PSN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The condition must never be true at a checked edge.
`define PSN_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[src/psn_pkg.sv]
package psn_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SUM_W      = 38;
   localparam int ACC_W      = 72;
   localparam int DIV_W      = 72;
   localparam int STEP_W     = 7;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   // Iterations of the shared divider for each job
   localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(SUM_W);
   localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(ACC_W);
   localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(48);

   // Request to the shared divider; dividend is left aligned
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [DIV_W-1:0]  dividend;
      logic [31:0]       divisor;
   } div_req_type;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_MEAN_GO = 14'b00000000000010,
      S_MEAN_W  = 14'b00000000000100,
      S_VRD     = 14'b00000000001000,
      S_VMUL    = 14'b00000000010000,
      S_VACC    = 14'b00000000100000,
      S_VDIV_GO = 14'b00000001000000,
      S_VDIV_W  = 14'b00000010000000,
      S_SQRT_GO = 14'b00000100000000,
      S_SQRT_W  = 14'b00001000000000,
      S_ORD     = 14'b00010000000000,
      S_NDIV_GO = 14'b00100000000000,
      S_NDIV_W  = 14'b01000000000000,
      S_SEND    = 14'b10000000000000
   } state_type;

endpackage

[src/psn_div.sv]
// Restoring divider, one quotient bit per cycle
module psn_div import psn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       dsr_ff, dsr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [32:0]       shifted;
   logic [32:0]       trial;
   logic              fits;

   // one trial subtraction
   assign shifted = {rem_ff, num_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? trial[31:0] : shifted[31:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[src/psn_sqrt.sv]
// Integer square root, one root bit per cycle
module psn_sqrt import psn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);

   logic [63:0] x_ff, x_in;
   logic [31:0] root_ff, root_in;
   logic [34:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] rem_sh;
   logic [34:0] trial;
   logic        fits;

   // bring down two bits and try root*4+1
   assign rem_sh = {rem_ff[32:0], x_ff[63:62]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      x_in    = x_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[61:0], 2'b00};
         root_in = {root_ff[30:0], fits};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

[src/point_set_normalizer_core.sv]
// Channel   Dir  Payload                                          Marker
// req_      in   point_x, point_y, point_z                        tlast = last_point
// rsp_      out  norm_x..z, mean_x..z, rms_scale, tuser=overflowed tlast = last_result
//
// A point without the last mark is taken in idle and the input stays ready.
// Closing a set of n points: three divisions for the means, the sum of squared
// distances over the stored points, its division by n, the root, then three
// divisions and a send per result; the shared divider gives one quotient bit a cycle.
// Reset is synchronous and clears count, sums and the drop flag; the store
// needs no clearing. req_tready is low from the closing point until the last
// result transaction; a stalled result holds the sequencer.
`include "assert_macros.svh"

module point_set_normalizer_core import psn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // point_x, point_y, point_z
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [223:0] rsp_tdata,  // norm_x, norm_y, norm_z, mean_x, mean_y, mean_z, rms_scale
   output logic         rsp_tuser,  // overflowed
   output logic         rsp_tlast
);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];
   logic                    drop_ff, drop_in;
   logic [31:0]             mean_ff [3];
   logic [31:0]             mean_in [3];
   logic [31:0]             norm_ff [3];
   logic [31:0]             norm_in [3];
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [63:0]             prod_ff;
   logic [31:0]             scale_ff, scale_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [1:0]              axis_ff, axis_in;
   logic [95:0]             mem [MAX_POINTS];
   logic [95:0]             rd_ff;

   logic                    req_fire;
   logic                    room;
   logic                    idx_last;
   logic [31:0]             coord;
   logic signed [32:0]      diff;
   logic [31:0]             abs_d;
   logic                    diff_neg;
   logic [SUM_W-1:0]        abs_sum;
   div_req_type             div_req;
   logic [DIV_W-1:0]        div_q;
   logic                    div_done;
   logic [31:0]             root;
   logic                    sqrt_done;
   logic [31:0]             sat_q;

   assign req_fire   = req_tvalid && req_tready;
   assign room       = count_ff < CNT_W'(MAX_POINTS);
   assign idx_last   = (CNT_W'(idx_ff) + 1'b1) == count_ff;

   // distance of the stored coordinate from the mean, current axis
   always_comb begin
      case (axis_ff)
         2'd0:    coord = rd_ff[31:0];
         2'd1:    coord = rd_ff[63:32];
         2'd2:    coord = rd_ff[95:64];
         default: coord = rd_ff[31:0];
      endcase
   end
   assign diff     = $signed({coord[31], coord}) - $signed({mean_ff[axis_ff][31], mean_ff[axis_ff]});
   assign diff_neg = diff[32];
   assign abs_d    = diff_neg ? 32'(-diff) : diff[31:0];
   assign abs_sum  = sum_ff[axis_ff][SUM_W-1] ? SUM_W'(-sum_ff[axis_ff])
                                               : SUM_W'(sum_ff[axis_ff]);

   // truncated quotient of the normalizing division, saturated
   always_comb begin
      if (diff_neg) begin
         sat_q = (div_q[47:0] > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-div_q[31:0]);
      end else begin
         sat_q = (div_q[47:0] > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
      end
   end

   // requests to the shared divider
   always_comb begin
      div_req = '0;
      case (state_ff)
         S_MEAN_GO: begin
            div_req.start    = 1'b1;
            div_req.steps    = MEAN_STEPS;
            div_req.dividend = {abs_sum, (DIV_W - SUM_W)'(0)};
            div_req.divisor  = 32'(count_ff);
         end
         S_VDIV_GO: begin
            div_req.start    = 1'b1;
            div_req.steps    = VAR_STEPS;
            div_req.dividend = acc_ff;
            div_req.divisor  = 32'(count_ff);
         end
         S_NDIV_GO: begin
            div_req.start    = 1'b1;
            div_req.steps    = NORM_STEPS;
            div_req.dividend = {abs_d, 16'h0000, 24'h000000};
            div_req.divisor  = scale_ff;
         end
         default: div_req = '0;
      endcase
   end

   psn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .quotient (div_q),
      .done     (div_done)
   );

   psn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_SQRT_GO),
      .radicand (div_q[63:0]),
      .root     (root),
      .done     (sqrt_done)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      mean_in  = mean_ff;
      norm_in  = norm_ff;
      acc_in   = acc_ff;
      scale_in = scale_ff;
      idx_in   = idx_ff;
      axis_in  = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (room) begin
                  count_in  = count_ff + 1'b1;
                  sum_in[0] = sum_ff[0] + SUM_W'($signed(req_tdata[31:0]));
                  sum_in[1] = sum_ff[1] + SUM_W'($signed(req_tdata[63:32]));
                  sum_in[2] = sum_ff[2] + SUM_W'($signed(req_tdata[95:64]));
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  if (count_in == '0) begin
                     drop_in = 1'b0;
                  end else begin
                     axis_in  = 2'd0;
                     state_in = S_MEAN_GO;
                  end
               end
            end
         end
         S_MEAN_GO: state_in = S_MEAN_W;
         S_MEAN_W: begin
            if (div_done) begin
               mean_in[axis_ff] = sum_ff[axis_ff][SUM_W-1] ? 32'(-div_q[31:0]) : div_q[31:0];
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  idx_in   = '0;
                  acc_in   = '0;
                  state_in = S_VRD;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_MEAN_GO;
               end
            end
         end
         S_VRD:  state_in = S_VMUL;
         S_VMUL: state_in = S_VACC;
         S_VACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               if (idx_last) begin
                  state_in = S_VDIV_GO;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_VRD;
               end
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_VMUL;
            end
         end
         S_VDIV_GO: state_in = S_VDIV_W;
         S_VDIV_W: begin
            if (div_done) begin
               idx_in  = '0;
               axis_in = 2'd0;
               if (div_q[DIV_W-1:64] != '0) begin
                  scale_in = 32'hFFFF_FFFF;
                  state_in = S_ORD;
               end else begin
                  state_in = S_SQRT_GO;
               end
            end
         end
         S_SQRT_GO: state_in = S_SQRT_W;
         S_SQRT_W: begin
            if (sqrt_done) begin
               scale_in = (root == '0) ? ONE_Q16 : root;
               state_in = S_ORD;
            end
         end
         S_ORD:     state_in = S_NDIV_GO;
         S_NDIV_GO: state_in = S_NDIV_W;
         S_NDIV_W: begin
            if (div_done) begin
               norm_in[axis_ff] = sat_q;
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  state_in = S_SEND;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_NDIV_GO;
               end
            end
         end
         S_SEND: begin
            if (rsp_tready) begin
               if (idx_last) begin
                  count_in = '0;
                  sum_in   = '{default: '0};
                  drop_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // point store: write on load, registered read while sweeping
   always_ff @(posedge clock) begin
      if (req_fire && room) begin
         mem[count_ff[IDX_W-1:0]] <= req_tdata;
      end
      if (state_ff == S_VRD || state_ff == S_ORD) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      mean_ff  <= mean_in;
      norm_ff  <= norm_in;
      acc_ff   <= acc_in;
      scale_ff <= scale_in;
      idx_ff   <= idx_in;
      axis_ff  <= axis_in;
      prod_ff  <= abs_d * abs_d;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         sum_ff   <= '{default: '0};
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         drop_ff  <= drop_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SEND);
   assign rsp_tdata  = {scale_ff, mean_ff[2], mean_ff[1], mean_ff[0],
                        norm_ff[2], norm_ff[1], norm_ff[0]};
   assign rsp_tuser  = drop_ff;
   assign rsp_tlast  = idx_last;

   `PSN_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_POINTS), "point count beyond store depth")
   `PSN_NEVER(a_busy_overlap, rsp_tvalid && req_tready, "input ready while a result is shown")
   `PSN_ASSERT(a_set_cleared, (rsp_tvalid && rsp_tready && rsp_tlast) |=> (count_ff == '0), "set not cleared after last result")
   `PSN_ASSERT(a_div_owner, div_done |-> (state_ff == S_MEAN_W || state_ff == S_VDIV_W || state_ff == S_NDIV_W), "divider finished outside a wait state")
   `PSN_ASSERT(a_scale_nonzero, rsp_tvalid |-> (scale_ff != '0), "zero scale on a result")

endmodule
